[src/assert_macros.svh]
// Assertion macros shared by the frame receiver RTL.
// Include with the bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define CFR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen on a clock edge outside reset.
`define CFR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[src/cfr_pkg.sv]
// Types, constants and a helper function for the checksummed frame receiver.
// No dependencies; used by the interfaces, the parser and the top level.
package cfr_pkg;

    localparam int ByteW = 8;
    localparam int CfgIdxW = 1;

    localparam logic [ByteW-1:0] StartMarkerRst = 8'hB0;
    localparam logic [ByteW-1:0] EndMarkerRst = 8'hB1;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] RegStartMarker = 1'b0;
    localparam logic [CfgIdxW-1:0] RegEndMarker = 1'b1;

    // ASCII ranges of lower-case hex digits
    localparam logic [ByteW-1:0] ChZero = 8'h30;
    localparam logic [ByteW-1:0] ChNine = 8'h39;
    localparam logic [ByteW-1:0] ChLowA = 8'h61;
    localparam logic [ByteW-1:0] ChLowF = 8'h66;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_DIGITS  = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Result of parsing one word, handed from the parser to the top level
    typedef struct packed {
        logic             has_res;
        logic [ByteW-1:0] payload_byte;
        logic             frame_end;
        logic             checksum_ok;
    } t_parse_res;

    // Decode a lower-case hex digit
    function automatic t_hex hex_decode(input logic [ByteW-1:0] c);
        t_hex r;
        logic [ByteW-1:0] d;
        r = '0;
        d = '0;
        if (c >= ChZero && c <= ChNine) begin
            d = c - ChZero;
            r.ok = 1'b1;
            r.val = d[3:0];
        end else if (c >= ChLowA && c <= ChLowF) begin
            d = c - ChLowA + 8'd10;
            r.ok = 1'b1;
            r.val = d[3:0];
        end
        return r;
    endfunction

endpackage

[src/cfr_ifs.sv]
// Valid/ready channel interfaces for received words and frame results.
// Depends on cfr_pkg for the byte width.
interface cfr_rx_if;
    logic                      valid;
    logic                      ready;
    logic [cfr_pkg::ByteW-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfr_res_if;
    logic                      valid;
    logic                      ready;
    logic [cfr_pkg::ByteW-1:0] payload_byte;
    logic                      frame_end;
    logic                      checksum_ok;

    modport source (output valid, output payload_byte, output frame_end,
                    output checksum_ok, input ready);
    modport sink (input valid, input payload_byte, input frame_end,
                  input checksum_ok, output ready);
endinterface

[src/cfr_parser.sv]
// Frame parser: phase machine, checksum digit capture and running payload sum.
// Depends on cfr_pkg for the phase type, hex decode and the result struct.
module cfr_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [cfr_pkg::ByteW-1:0] i_byte,
    input  logic                      i_fire,
    input  logic [cfr_pkg::ByteW-1:0] i_start_marker,
    input  logic [cfr_pkg::ByteW-1:0] i_end_marker,
    output cfr_pkg::t_parse_res       o_res
);
    import cfr_pkg::*;

    t_phase           r_phase, n_phase;
    logic             r_digit, n_digit;
    logic [ByteW-1:0] r_expected, n_expected;
    logic [ByteW-1:0] r_running, n_running;
    t_hex             hex;

    assign hex = hex_decode(i_byte);

    // Work out the result and the next state for the word in the input register
    always_comb begin
        n_phase = r_phase;
        n_digit = r_digit;
        n_expected = r_expected;
        n_running = r_running;
        o_res = '0;
        case (r_phase)
            PH_DIGITS: begin
                if (hex.ok) begin
                    n_expected = {r_expected[3:0], hex.val};
                    if (r_digit) begin
                        n_digit = 1'b0;
                        n_running = '0;
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_digit = 1'b1;
                    end
                end else begin
                    // drop the frame, keep the partial checksum
                    n_digit = 1'b0;
                    n_phase = PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                o_res.has_res = 1'b1;
                if (i_byte == i_end_marker) begin
                    o_res.frame_end = 1'b1;
                    o_res.checksum_ok = (r_running == r_expected);
                    n_running = '0;
                    n_digit = 1'b0;
                    n_phase = PH_HUNT;
                end else begin
                    o_res.payload_byte = i_byte;
                    n_running = r_running + i_byte;
                end
            end
            default: begin
                if (i_byte == i_start_marker) begin
                    n_phase = PH_DIGITS;
                    n_digit = 1'b0;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    // Advance the state only when the word is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_digit <= 1'b0;
            r_expected <= '0;
            r_running <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_digit <= n_digit;
            r_expected <= n_expected;
            r_running <= n_running;
        end
    end

endmodule

[src/checksummed_frame_receiver_top.sv]
// Checksummed frame receiver: input register, parser and result register.
// Depends on cfr_pkg, cfr_ifs (channels), cfr_parser and assert_macros.svh.
//
// Usage:
//   i_rx carries received words, one byte each. A frame is the start marker,
//   two lower-case hex digits (high first) giving the expected 8-bit sum,
//   payload bytes, then the end marker. Each payload byte appears on o_res
//   with frame_end low; the end marker gives one word with frame_end high,
//   payload_byte zero and checksum_ok set if the byte sum modulo 256 matched.
//   Bytes outside frames and the header bytes give no output word.
//   Throughput is one word per cycle while the sink keeps ready high. A
//   taken word is parsed from the input register, and its result passes
//   through the result register to o_res.
//   When the sink holds ready low, the result register holds its word, the
//   input register still takes one more word, and i_rx.ready then falls
//   only if that word would also produce a result.
//   Markers are written on i_cfg_* (index 0 start, 1 end) while idle.
//   Reset (synchronous, active low) empties both registers, restores the
//   markers to B0/B1 hex and puts the parser back to hunting.
`include "assert_macros.svh"

module checksummed_frame_receiver_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cfr_rx_if.sink                      i_rx,
    cfr_res_if.source                   o_res,
    input  logic                        i_cfg_we,
    input  logic [cfr_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [cfr_pkg::ByteW-1:0]   i_cfg_data
);
    import cfr_pkg::*;

    logic [ByteW-1:0] r_start_marker;
    logic [ByteW-1:0] r_end_marker;
    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_out_valid;
    t_parse_res       r_out;
    t_parse_res       parse_res;
    logic             out_free;
    logic             fire;

    // Marker registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= StartMarkerRst;
            r_end_marker <= EndMarkerRst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegStartMarker: r_start_marker <= i_cfg_data;
                RegEndMarker:   r_end_marker <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Consume the held word once its result, if any, has somewhere to go
    assign out_free = !r_out_valid || o_res.ready;
    assign fire = r_in_valid && (!parse_res.has_res || out_free);
    assign i_rx.ready = !r_in_valid || fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    cfr_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte         (r_in_byte),
        .i_fire         (fire),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_res          (parse_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && parse_res.has_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && fire && parse_res.has_res) begin
            r_out <= parse_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.payload_byte = r_out.payload_byte;
    assign o_res.frame_end = r_out.frame_end;
    assign o_res.checksum_ok = r_out.checksum_ok;

    // Checks on the internal pipeline
    `CFR_ASSERT(a_hold_input, i_clk, i_rst_n, r_in_valid && !fire |=> r_in_valid && $stable(r_in_byte), "held input word lost or changed")
    `CFR_ASSERT(a_hold_output, i_clk, i_rst_n, r_out_valid && !o_res.ready |=> r_out_valid && $stable(r_out), "stalled result changed")
    `CFR_ASSERT_NEVER(a_end_payload, i_clk, i_rst_n, r_out_valid && r_out.frame_end && r_out.payload_byte != '0, "end word carries a payload byte")
    `CFR_ASSERT_NEVER(a_ok_without_end, i_clk, i_rst_n, r_out_valid && r_out.checksum_ok && !r_out.frame_end, "checksum flag on a payload word")

endmodule

[tb/tb_checksummed_frame_receiver_top.sv]
// Self-checking testbench for the checksummed frame receiver top level.
// Depends on cfr_pkg, the cfr_rx_if/cfr_res_if channels and the RTL under src.
module tb_checksummed_frame_receiver_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cfr_pkg::*;

    localparam int QuietLimit = 3000;
    localparam int ChokeCycles = 300;
    localparam logic [7:0] ChUpA = 8'h41;
    localparam logic [7:0] ChUpF = 8'h46;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_end;
        logic       checksum_ok;
    } t_frame_word;

    typedef enum logic [1:0] {
        NOISE_JUNK,
        NOISE_BAD_FIRST,
        NOISE_BAD_SECOND,
        NOISE_UPPER
    } t_noise_kind;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CfgIdxW-1:0]   cfg_idx;
    logic [ByteW-1:0]     cfg_data;

    cfr_rx_if  rx_if ();
    cfr_res_if res_if ();

    checksummed_frame_receiver_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predicted receiver state and markers
    logic [7:0]  start_mk;
    logic [7:0]  end_mk;
    t_phase      rx_phase;
    bit          digits_seen;
    logic [7:0]  header_sum;
    logic [7:0]  payload_sum;

    t_frame_word awaited_words[$];
    logic [7:0]  rx_backlog[$];

    bit          steady_mode;
    int          bytes_queued;
    int          bytes_taken;
    int          words_seen;
    int          frames_closed;
    int          sums_matched;
    int          marker_sets;
    int          chokes;
    int          fault_count;

    int          src_wait;
    int          sink_wait;
    int          choke_left;
    int          next_choke;

    function automatic bit lower_hex(input logic [7:0] c, output logic [3:0] nib);
        nib = '0;
        if (c >= ChZero && c <= ChNine) begin
            nib = 4'(c - ChZero);
            return 1'b1;
        end
        if (c >= ChLowA && c <= ChLowF) begin
            nib = 4'(c - ChLowA + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? ChZero + 8'(nib) : ChLowA + 8'(nib) - 8'd10;
    endfunction

    // Advance the predicted state by one accepted byte, queue any word it gives
    function automatic void track_rx_byte(input logic [7:0] c);
        logic [3:0] nib;
        case (rx_phase)
            PH_DIGITS: begin
                if (lower_hex(c, nib)) begin
                    header_sum = {header_sum[3:0], nib};
                    if (digits_seen) begin
                        digits_seen = 1'b0;
                        payload_sum = '0;
                        rx_phase = PH_PAYLOAD;
                    end else begin
                        digits_seen = 1'b1;
                    end
                end else begin
                    digits_seen = 1'b0;
                    rx_phase = PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                if (c == end_mk) begin
                    awaited_words.push_back('{8'h00, 1'b1, payload_sum == header_sum});
                    frames_closed++;
                    if (payload_sum == header_sum) sums_matched++;
                    payload_sum = '0;
                    digits_seen = 1'b0;
                    rx_phase = PH_HUNT;
                end else begin
                    payload_sum = payload_sum + c;
                    awaited_words.push_back('{c, 1'b0, 1'b0});
                end
            end
            default: begin
                if (c == start_mk) begin
                    rx_phase = PH_DIGITS;
                    digits_seen = 1'b0;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end
        endcase
    endfunction

    // Mostly short gaps, now and then a long one; none in steady stretches
    function automatic int pick_gap();
        int r;
        if (steady_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        logic [3:0] nib;
        if ($urandom_range(0, 4) == 0 && !lower_hex(start_mk, nib)) return start_mk;
        do b = 8'($urandom_range(0, 255));
        while (lower_hex(b, nib));
        return b;
    endfunction

    task automatic send(input logic [7:0] b);
        rx_backlog.push_back(b);
        bytes_queued++;
    endtask

    task automatic send_header(input logic [7:0] sum);
        send(start_mk);
        send(hex_char(sum[7:4]));
        send(hex_char(sum[3:0]));
    endtask

    // One well-formed frame, random body, checksum right about half the time
    task automatic queue_frame();
        logic [7:0] body[$];
        logic [7:0] sum;
        logic [7:0] b;
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 40) : $urandom_range(0, 10);
        sum = '0;
        for (int i = 0; i < len; i++) begin
            b = ($urandom_range(0, 15) == 0) ? start_mk : 8'($urandom_range(0, 255));
            if (b == end_mk) b = b ^ 8'h01;
            body.push_back(b);
            sum = sum + b;
        end
        send_header($urandom_range(0, 1) ? sum : 8'($urandom_range(0, 255)));
        foreach (body[i]) send(body[i]);
        send(end_mk);
    endtask

    // Line noise and broken headers
    task automatic queue_noise();
        t_noise_kind kind;
        int n;
        kind = t_noise_kind'($urandom_range(0, 3));
        case (kind)
            NOISE_JUNK: begin
                n = $urandom_range(1, 4);
                repeat (n) send(8'($urandom_range(0, 255)));
            end
            NOISE_BAD_FIRST: begin
                send(start_mk);
                send(non_hex_byte());
            end
            NOISE_BAD_SECOND: begin
                send(start_mk);
                send(hex_char(4'($urandom_range(0, 15))));
                send(non_hex_byte());
            end
            default: begin
                send(start_mk);
                send(8'($urandom_range(ChUpA, ChUpF)));
            end
        endcase
    endtask

    // Hold until every byte is taken and every word has arrived, then drain
    task automatic wait_idle();
        do @(posedge i_clk);
        while (bytes_taken != bytes_queued || awaited_words.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_marker(input logic [CfgIdxW-1:0] idx, input logic [7:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == RegStartMarker) start_mk = value;
        else end_mk = value;
    endtask

    task automatic run_phase(input logic [7:0] s, input logic [7:0] e, input int nbytes,
                             input bit steady);
        int target;
        write_marker(RegStartMarker, s);
        write_marker(RegEndMarker, e);
        marker_sets++;
        steady_mode = steady;
        target = bytes_queued + nbytes;
        while (bytes_queued < target) begin
            if ($urandom_range(0, 99) < 75) queue_frame();
            else queue_noise();
        end
        wait_idle();
    endtask

    // Sender: offer backlog bytes, predict each accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= '0;
            src_wait = 0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                track_rx_byte(rx_if.rx_byte);
                bytes_taken++;
            end
            if (!rx_if.valid || rx_if.ready) begin
                if (src_wait != 0) begin
                    src_wait--;
                    rx_if.valid <= 1'b0;
                end else if (rx_backlog.size() != 0) begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= rx_backlog.pop_front();
                    src_wait = pick_gap();
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // Hold-off counter: a long stretch while the sender still has plenty to offer
    always @(posedge i_clk) begin : hold_off
        if (!i_rst_n) begin
            choke_left <= 0;
            next_choke <= 100;
        end else if (choke_left != 0) begin
            choke_left <= choke_left - 1;
        end else if (words_seen >= next_choke && rx_backlog.size() > 64) begin
            choke_left <= ChokeCycles;
            next_choke <= words_seen + 500;
            chokes++;
        end
    end

    // Receiver: check each word against the oldest prediction, stall at random
    always @(posedge i_clk) begin : sink_side
        t_frame_word want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (awaited_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got %02h/%0b/%0b", $time,
                             res_if.payload_byte, res_if.frame_end, res_if.checksum_ok);
                    fault_count++;
                end else begin
                    want = awaited_words.pop_front();
                    if (res_if.payload_byte !== want.payload_byte) begin
                        $display("%0t: payload_byte expected %02h got %02h", $time,
                                 want.payload_byte, res_if.payload_byte);
                        fault_count++;
                    end
                    if (res_if.frame_end !== want.frame_end) begin
                        $display("%0t: frame_end expected %0b got %0b", $time,
                                 want.frame_end, res_if.frame_end);
                        fault_count++;
                    end
                    if (res_if.checksum_ok !== want.checksum_ok) begin
                        $display("%0t: checksum_ok expected %0b got %0b", $time,
                                 want.checksum_ok, res_if.checksum_ok);
                        fault_count++;
                    end
                end
                words_seen++;
                sink_wait = pick_gap();
            end
            if (choke_left != 0) begin
                res_if.ready <= 1'b0;
            end else if (sink_wait != 0) begin
                sink_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge i_clk);
            if (!i_rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, QuietLimit);
        $display("FAIL checksummed_frame_receiver_top");
        $finish;
    end

    initial begin : stimulus
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;
        start_mk      = StartMarkerRst;
        end_mk        = EndMarkerRst;
        rx_phase      = PH_HUNT;
        digits_seen   = 1'b0;
        header_sum    = '0;
        payload_sum   = '0;
        steady_mode   = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words with the reset markers
        send(8'h00);
        send(8'hFF);
        send(end_mk);                       // end marker while hunting
        send_header(8'h01);
        send(end_mk);                       // empty payload, wrong sum
        send_header(8'h9F);
        send(8'h9F);
        send(end_mk);                       // matching sum
        send(start_mk);
        send(ChUpA);                        // upper-case digit drops the header
        send(start_mk);
        send(hex_char(4'h1));
        send(start_mk);                     // start marker among the digits
        send_header(8'hAE);
        send(8'hFF);
        send(start_mk);                     // start marker as payload, sum wraps
        send(8'hFF);
        send(end_mk);
        send(start_mk);
        send(ChLowF + 8'd1);                // first byte past the hex range
        wait_idle();

        // Extreme, hex-like and coinciding markers
        run_phase(8'h00, 8'hFF, 20, 1'b0);
        run_phase(8'hFF, 8'h00, 20, 1'b0);
        run_phase(ChZero, ChLowA, 20, 1'b0);
        run_phase(8'h55, 8'h55, 20, 1'b0);

        // Random markers and traffic, one stretch without idling
        for (int p = 0; p < 4; p++)
            run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 200, p == 1);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes over %0d marker settings; checked %0d words, %0d frame ends",
                 bytes_taken, marker_sets + 1, words_seen, frames_closed);
        $display("  (%0d with matching sums), with %0d long receiver hold-offs",
                 sums_matched, chokes);
        if (awaited_words.size() != 0)
            $display("%0t: %0d predicted words never arrived", $time, awaited_words.size());
        if (fault_count == 0 && awaited_words.size() == 0) begin
            $display("PASS checksummed_frame_receiver_top");
        end else begin
            $display("FAIL checksummed_frame_receiver_top");
        end
        $finish;
    end

endmodule
